### rtl/bplc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bplc_pkg: shared types and constants
// Types, widths and codes used by the button press length classifier.
// ----------------------------------------------------------------------------
package bplc_pkg;

    localparam int NUM_KEYS    = 4;
    localparam int TIMER_BITS  = 16;
    localparam int LONG_BITS   = 16;
    localparam int COUNT_BITS  = 16;
    localparam int CMP_BITS    = (TIMER_BITS > LONG_BITS) ? TIMER_BITS : LONG_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Button order within the lanes.
    localparam int KEY_MODE = 0;
    localparam int KEY_SET  = 1;
    localparam int KEY_UP   = 2;
    localparam int KEY_DOWN = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_PRESS_MODE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_LOW = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG_MODE  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG_SET   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG_UP    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG_DOWN  = 3'd5;

    // Press mode codes; the fourth code selects no classification.
    localparam logic [1:0] MODE_SHORT_LONG = 2'd0;
    localparam logic [1:0] MODE_SHORT_ONLY = 2'd1;
    localparam logic [1:0] MODE_LONG_ONLY  = 2'd2;

    // Reset values of the thresholds.
    localparam logic [LONG_BITS-1:0] LONG_MODE_RST = 16'd1000;
    localparam logic [LONG_BITS-1:0] LONG_SET_RST  = 16'd500;
    localparam logic [LONG_BITS-1:0] LONG_UP_RST   = 16'd1000;
    localparam logic [LONG_BITS-1:0] LONG_DOWN_RST = 16'd1000;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } event_t;

    typedef struct packed {
        event_t                ev;
        logic [COUNT_BITS-1:0] count;
    } lane_res_t;

endpackage
`default_nettype wire

### rtl/bplc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bplc_in_if: scan tick channel
// Carries the raw pin levels of the four buttons with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bplc_in_if;
    logic valid;
    logic ready;
    logic pin_mode_key;
    logic pin_set_key;
    logic pin_up_key;
    logic pin_down_key;

    modport source (
        output valid, pin_mode_key, pin_set_key, pin_up_key, pin_down_key,
        input  ready
    );
    modport sink (
        input  valid, pin_mode_key, pin_set_key, pin_up_key, pin_down_key,
        output ready
    );
endinterface
`default_nettype wire

### rtl/bplc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bplc_out_if: result channel
// Carries the per-button event codes and press counts of one scan tick.
// ----------------------------------------------------------------------------
interface bplc_out_if;
    import bplc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [1:0]            event_mode_key;
    logic [1:0]            event_set_key;
    logic [1:0]            event_up_key;
    logic [1:0]            event_down_key;
    logic [COUNT_BITS-1:0] count_mode_key;
    logic [COUNT_BITS-1:0] count_set_key;
    logic [COUNT_BITS-1:0] count_up_key;
    logic [COUNT_BITS-1:0] count_down_key;

    modport source (
        output valid, event_mode_key, event_set_key, event_up_key, event_down_key,
               count_mode_key, count_set_key, count_up_key, count_down_key,
        input  ready
    );
    modport sink (
        input  valid, event_mode_key, event_set_key, event_up_key, event_down_key,
               count_mode_key, count_set_key, count_up_key, count_down_key,
        output ready
    );
endinterface
`default_nettype wire

### rtl/bplc_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bplc_lane: per-button press classifier
// Holds one button's press timer and press counter and classifies each tick.
// ----------------------------------------------------------------------------
module bplc_lane
    import bplc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic                 pin,
    input  wire logic                 active_low,
    input  wire logic [1:0]           press_mode,
    input  wire logic [LONG_BITS-1:0] long_ticks,
    output lane_res_t                 res
);

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    logic [TIMER_BITS-1:0] timer_reg;
    logic [TIMER_BITS-1:0] timer_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;

    logic                  pressed;
    logic [TIMER_BITS-1:0] timer_inc;
    logic [CMP_BITS-1:0]   timer_ext;
    logic [CMP_BITS-1:0]   thr_ext;
    logic                  at_long;
    logic                  classify;
    event_t                ev;

    always_comb
    begin
        pressed   = active_low ? !pin : pin;
        timer_inc = (pressed && timer_reg != TIMER_MAX) ? timer_reg + 1'b1 : timer_reg;
        timer_ext = CMP_BITS'(timer_inc);
        thr_ext   = CMP_BITS'(long_ticks);
        at_long   = timer_ext >= thr_ext;
        // A release with time on the timer, or a hold beyond the threshold.
        classify  = (!pressed && timer_inc != '0) || (pressed && timer_ext > thr_ext);

        timer_next = timer_inc;
        count_next = count_reg;
        ev         = EV_NONE;
        if (classify)
        begin
            unique case (press_mode)
                MODE_SHORT_LONG:
                begin
                    if (at_long)
                    begin
                        ev = EV_LONG;
                        // A held button keeps reporting long until release.
                        if (!pressed)
                        begin
                            timer_next = '0;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        ev         = EV_SHORT;
                        timer_next = '0;
                        count_next = count_reg + 1'b1;
                    end
                end
                MODE_SHORT_ONLY:
                begin
                    ev         = EV_SHORT;
                    timer_next = '0;
                    count_next = count_reg + 1'b1;
                end
                MODE_LONG_ONLY:
                begin
                    if (at_long)
                    begin
                        ev         = EV_LONG;
                        timer_next = '0;
                        count_next = count_reg + 1'b1;
                    end
                    else if (!pressed)
                    begin
                        timer_next = '0;
                    end
                end
                default:
                begin
                    timer_next = timer_inc;
                end
            endcase
        end
        res.ev    = ev;
        res.count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            timer_reg <= timer_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_short_counts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.ev == EV_SHORT |=> count_reg == $past(count_reg) + 1'b1)
        else $error("short press did not advance the press counter");

    a_none_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.ev == EV_NONE |=> $stable(count_reg))
        else $error("press counter moved on a tick with no event");

    a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(timer_reg) && $stable(count_reg))
        else $error("lane state changed without a transfer");
`endif

endmodule
`default_nettype wire

### rtl/bplc_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bplc_merge: result register
// Gathers the four lane results into one result item and holds it for the
// receiver; it accepts a new tick whenever the register is empty or drains.
// ----------------------------------------------------------------------------
module bplc_merge
    import bplc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire lane_res_t [NUM_KEYS-1:0] lanes,
    bplc_out_if.source                    res_out
);

    logic                     valid_reg;
    logic                     valid_next;
    lane_res_t [NUM_KEYS-1:0] res_reg;

    assign in_ready = !valid_reg || res_out.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (res_out.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            res_reg <= lanes;
        end
    end

    assign res_out.valid          = valid_reg;
    assign res_out.event_mode_key = res_reg[KEY_MODE].ev;
    assign res_out.event_set_key  = res_reg[KEY_SET].ev;
    assign res_out.event_up_key   = res_reg[KEY_UP].ev;
    assign res_out.event_down_key = res_reg[KEY_DOWN].ev;
    assign res_out.count_mode_key = res_reg[KEY_MODE].count;
    assign res_out.count_set_key  = res_reg[KEY_SET].count;
    assign res_out.count_up_key   = res_reg[KEY_UP].count;
    assign res_out.count_down_key = res_reg[KEY_DOWN].count;

`ifndef SYNTH
    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !res_out.ready |-> !in_ready)
        else $error("input taken while the result register is full and stalled");
`endif

endmodule
`default_nettype wire

### rtl/button_press_length_classifier_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// button_press_length_classifier_unit: short/long key press classifier
// Classifies presses of the mode, set, up and down buttons as short or long.
// ----------------------------------------------------------------------------
// Usage:
//   key_in carries one scan tick per transfer: the raw pin level of each of
//   the four buttons. res_out carries one result per tick: an event code for
//   each button (none, short, long) and its wrapping press count after the
//   tick. The cfg_we/cfg_index/cfg_data port writes the press mode, the pin
//   polarity and the four long thresholds; write it only while idle.
//   A transferred tick's result is registered and shown on res_out from the
//   cycle after the transfer. Throughput is one tick per cycle while the
//   receiver takes each result; the four buttons are handled by separate
//   lanes that compare and increment their timers and counters combinationally.
//   Reset clears all timers and counters, empties the result register and
//   loads the register defaults (short and long mode, active low pins,
//   thresholds 1000, 500, 1000, 1000).
//   When the receiver stalls, the result register holds its item and key_in
//   ready falls until the item is transferred; no tick is lost.
// ----------------------------------------------------------------------------
module button_press_length_classifier_unit
    import bplc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    bplc_in_if.sink                       key_in,
    bplc_out_if.source                    res_out
);

    logic [1:0]           press_mode_reg;
    logic                 active_low_reg;
    logic [LONG_BITS-1:0] long_ticks_reg [NUM_KEYS];

    logic                     accept;
    logic                     merge_ready;
    logic [NUM_KEYS-1:0]      pins;
    lane_res_t [NUM_KEYS-1:0] lanes;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_mode_reg           <= MODE_SHORT_LONG;
            active_low_reg           <= 1'b1;
            long_ticks_reg[KEY_MODE] <= LONG_MODE_RST;
            long_ticks_reg[KEY_SET]  <= LONG_SET_RST;
            long_ticks_reg[KEY_UP]   <= LONG_UP_RST;
            long_ticks_reg[KEY_DOWN] <= LONG_DOWN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PRESS_MODE: press_mode_reg           <= cfg_data[1:0];
                REG_ACTIVE_LOW: active_low_reg           <= cfg_data[0];
                REG_LONG_MODE:  long_ticks_reg[KEY_MODE] <= cfg_data[LONG_BITS-1:0];
                REG_LONG_SET:   long_ticks_reg[KEY_SET]  <= cfg_data[LONG_BITS-1:0];
                REG_LONG_UP:    long_ticks_reg[KEY_UP]   <= cfg_data[LONG_BITS-1:0];
                REG_LONG_DOWN:  long_ticks_reg[KEY_DOWN] <= cfg_data[LONG_BITS-1:0];
                default:        press_mode_reg           <= press_mode_reg;
            endcase
        end
    end

    assign key_in.ready = merge_ready;
    assign accept       = key_in.valid && merge_ready;

    assign pins[KEY_MODE] = key_in.pin_mode_key;
    assign pins[KEY_SET]  = key_in.pin_set_key;
    assign pins[KEY_UP]   = key_in.pin_up_key;
    assign pins[KEY_DOWN] = key_in.pin_down_key;

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        bplc_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .accept     (accept),
            .pin        (pins[k]),
            .active_low (active_low_reg),
            .press_mode (press_mode_reg),
            .long_ticks (long_ticks_reg[k]),
            .res        (lanes[k])
        );
    end

    bplc_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (key_in.valid),
        .in_ready (merge_ready),
        .lanes    (lanes),
        .res_out  (res_out)
    );

`ifndef SYNTH
    a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_out.valid)
        else $error("transferred tick produced no result");
`endif

endmodule
`default_nettype wire
